>>> rtl/core/terrain_height_interpolator_assert.svh
// Assertion macros for the terrain height interpolator.
`ifndef TERRAIN_HEIGHT_INTERPOLATOR_ASSERT_SVH
`define TERRAIN_HEIGHT_INTERPOLATOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define THI_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thi: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define THI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thi: next-cycle check failed");

`endif

>>> rtl/core/thi_pkg.sv
package thi_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SIDE_DEF  = 512;
  localparam int FRAC_BITS_DEF = 8;

  // Fixed field widths.
  localparam int POS_W      = 24;
  localparam int INV_W      = 16;
  localparam int CELL_W     = 9;
  localparam int HEIGHT_W   = 8;
  localparam int OUT_W      = 16;
  localparam int OUT_FRAC_W = 8;
  localparam int CFG_DIM_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Binary point of pos * inv_scale (Q.8 times Q.12).
  localparam int GRID_POINT = 20;

  localparam int HEIGHT_Q8_MAX = 65280;

  localparam logic [CFG_DIM_W-1:0] MAP_DIM_RESET   = CFG_DIM_W'(512);
  localparam logic [INV_W-1:0]     INV_SCALE_RESET = INV_W'(4096);

  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Z = 2'd3;

  // Input action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Class of a word after the front end has looked at it.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,  // store one height byte
    OP_QUERY = 2'd1,  // interpolate inside the map
    OP_MISS  = 2'd2,  // query outside the map
    OP_DROP  = 2'd3   // write to a cell beyond the store
  } op_e;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // Bits of one queue entry: op, x, z, xinc, zinc, fx, fz, rev, data.
  function automatic int entry_width(int xw, int frac);
    return 2 + 2 * xw + 2 + 2 * frac + 1 + HEIGHT_W;
  endfunction

endpackage

>>> rtl/core/terrain_height_interpolator.sv
// Terrain height interpolator: holds a MAX_SIDE x MAX_SIDE map of 8-bit heights and answers
// height queries at world positions with a bilinear blend over one triangle of the cell, in
// Q8.8. Each input word is either a height write (no result) or a query (exactly one
// result). The block takes one word per cycle and returns one result per cycle while
// neither in_stall_o nor out_stall_i holds it; a write is seen by every query accepted
// after it. The rate is set by the height store, which is split into four banks by column
// and row parity so that the four corners of a cell come from one read port per bank in a
// single cycle. A front end registers the word, scales the position by the reciprocal
// cell spacing and classifies it (write, dropped write, query inside the map, query
// outside the map); a four-word queue separates it from the back end, which runs the
// store access and three arithmetic stages into an output register. The store has no
// clearing pass and is usable right after reset; a query that touches a cell never
// written returns an undefined height. The user must write configuration registers only
// while no word is in flight; the block does not enforce this. cfg_ready_o is always high.

`include "terrain_height_interpolator_assert.svh"

module terrain_height_interpolator import thi_pkg::*; #(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [CELL_W-1:0]      cell_x_i,
  input  logic [CELL_W-1:0]      cell_z_i,
  input  logic [HEIGHT_W-1:0]    height_byte_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic                   reverse_quad_i,

  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [OUT_W-1:0]       height_q8_o,
  output logic                   out_of_range_o
);

  localparam int XW = $clog2(MAX_SIDE);
  localparam int EW = entry_width(XW, FRAC_BITS);

  // Configuration registers.
  logic [CFG_DIM_W-1:0] map_width_q;
  logic [CFG_DIM_W-1:0] map_length_q;
  logic [INV_W-1:0]     inv_scale_x_q;
  logic [INV_W-1:0]     inv_scale_z_q;

  // Queue between the front end and the back end.
  logic                 q_push;
  logic                 q_pop;
  logic [EW-1:0]        q_entry;
  logic [EW-1:0]        q_head;
  queue_status_t        q_status;

  assign cfg_ready_o = 1'b1;

  // Take a register write in any cycle; a word past the list of registers does nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q   <= MAP_DIM_RESET;
      map_length_q  <= MAP_DIM_RESET;
      inv_scale_x_q <= INV_SCALE_RESET;
      inv_scale_z_q <= INV_SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAP_WIDTH:   map_width_q   <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_MAP_LENGTH:  map_length_q  <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_INV_SCALE_X: inv_scale_x_q <= cfg_data_i[INV_W-1:0];
        CFG_INV_SCALE_Z: inv_scale_z_q <= cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: register the word, scale to grid units, range check, classify.
  thi_front #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .cell_x_i       (cell_x_i),
    .cell_z_i       (cell_z_i),
    .height_byte_i  (height_byte_i),
    .pos_x_i        (pos_x_i),
    .pos_z_i        (pos_z_i),
    .reverse_quad_i (reverse_quad_i),
    .map_width_i    (map_width_q),
    .map_length_i   (map_length_q),
    .inv_scale_x_i  (inv_scale_x_q),
    .inv_scale_z_i  (inv_scale_z_q),
    .q_status_i     (q_status),
    .push_o         (q_push),
    .entry_o        (q_entry)
  );

  // Short queue: lets the front end keep taking words while the output is held.
  thi_queue #(
    .W (EW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_entry),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  // Back end: banked height store, triangle repair, two blend stages, rounding.
  thi_back #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .q_status_i     (q_status),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .height_q8_o    (height_q8_o),
    .out_of_range_o (out_of_range_o)
  );

  // The back end drains the queue whenever the output side is free.
  `THI_ASSERT_IMPLIES(a_pop_when_free, clk_i, rst_ni, !q_status.empty && !out_stall_i, q_pop)
  // A miss carries a zero height.
  `THI_ASSERT_IMPLIES(a_miss_zero, clk_i, rst_ni, out_valid_o && out_of_range_o, height_q8_o == '0)
  // Rounded height stays within Q8.8 of an 8-bit map.
  `THI_ASSERT_IMPLIES(a_height_max, clk_i, rst_ni, out_valid_o, height_q8_o <= OUT_W'(HEIGHT_Q8_MAX))
  // The queue cannot fill up on its own.
  `THI_ASSERT_NEXT(a_queue_idle, clk_i, rst_ni, q_status.empty && !q_push, q_status.empty)

endmodule

>>> rtl/core/thi_front.sv
module thi_front import thi_pkg::*; #(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      action_i,
  input  logic [CELL_W-1:0]                         cell_x_i,
  input  logic [CELL_W-1:0]                         cell_z_i,
  input  logic [HEIGHT_W-1:0]                       height_byte_i,
  input  logic signed [POS_W-1:0]                   pos_x_i,
  input  logic signed [POS_W-1:0]                   pos_z_i,
  input  logic                                      reverse_quad_i,
  input  logic [CFG_DIM_W-1:0]                      map_width_i,
  input  logic [CFG_DIM_W-1:0]                      map_length_i,
  input  logic [INV_W-1:0]                          inv_scale_x_i,
  input  logic [INV_W-1:0]                          inv_scale_z_i,
  input  queue_status_t                             q_status_i,
  output logic                                      push_o,
  output logic [entry_width($clog2(MAX_SIDE), FRAC_BITS)-1:0] entry_o
);

  localparam int F    = FRAC_BITS;
  localparam int XW   = $clog2(MAX_SIDE);
  localparam int DW   = $clog2(MAX_SIDE + 1);
  localparam int MW   = (CFG_DIM_W > DW) ? CFG_DIM_W : DW;
  localparam int CmpW = (CELL_W > DW) ? CELL_W : DW;
  localparam int PW   = POS_W + INV_W + 1;
  localparam int IW   = PW - 1 - GRID_POINT;

  typedef struct packed {
    op_e                 op;
    logic [XW-1:0]       x;
    logic [XW-1:0]       z;
    logic                xinc;
    logic                zinc;
    logic [F-1:0]        fx;
    logic [F-1:0]        fz;
    logic                rev;
    logic [HEIGHT_W-1:0] data;
  } entry_t;

  logic                  fa_adv;
  logic                  fa_valid_q;
  logic                  action_q;
  logic [CELL_W-1:0]     cell_x_q;
  logic [CELL_W-1:0]     cell_z_q;
  logic [HEIGHT_W-1:0]   height_q;
  logic                  rev_q;
  logic signed [PW-1:0]  prod_x_d;
  logic signed [PW-1:0]  prod_z_d;
  logic signed [PW-1:0]  prod_x_q;
  logic signed [PW-1:0]  prod_z_q;

  logic [MW-1:0]         w_eff;
  logic [MW-1:0]         l_eff;
  logic [IW-1:0]         ix;
  logic [IW-1:0]         iz;
  logic                  x_in;
  logic                  z_in;
  logic                  cell_ok;
  entry_t                entry;

  // Scale position to grid units, Q.20.
  assign prod_x_d = PW'(pos_x_i) * PW'(signed'({1'b0, inv_scale_x_i}));
  assign prod_z_d = PW'(pos_z_i) * PW'(signed'({1'b0, inv_scale_z_i}));

  assign fa_adv     = !fa_valid_q || !q_status_i.full;
  assign in_stall_o = !fa_adv;
  assign push_o     = fa_valid_q && !q_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_valid_q <= 1'b0;
    end else if (fa_adv) begin
      fa_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fa_adv && in_valid_i) begin
      action_q <= action_i;
      cell_x_q <= cell_x_i;
      cell_z_q <= cell_z_i;
      height_q <= height_byte_i;
      rev_q    <= reverse_quad_i;
      prod_x_q <= prod_x_d;
      prod_z_q <= prod_z_d;
    end
  end

  // Clamp the map size to the store.
  assign w_eff = (MW'(map_width_i) > MW'(MAX_SIDE))  ? MW'(MAX_SIDE) : MW'(map_width_i);
  assign l_eff = (MW'(map_length_i) > MW'(MAX_SIDE)) ? MW'(MAX_SIDE) : MW'(map_length_i);

  assign ix   = prod_x_q[PW-2 -: IW];
  assign iz   = prod_z_q[PW-2 -: IW];
  assign x_in = !prod_x_q[PW-1] && (ix < IW'(w_eff));
  assign z_in = !prod_z_q[PW-1] && (iz < IW'(l_eff));

  assign cell_ok = (CmpW'(cell_x_q) < CmpW'(MAX_SIDE)) && (CmpW'(cell_z_q) < CmpW'(MAX_SIDE));

  always_comb begin
    entry.fx   = prod_x_q[GRID_POINT-1 -: F];
    entry.fz   = prod_z_q[GRID_POINT-1 -: F];
    entry.rev  = rev_q;
    entry.data = height_q;
    // Step to the next column or row unless that would leave the map.
    entry.xinc = (ix + IW'(1)) < IW'(w_eff);
    entry.zinc = (iz + IW'(1)) < IW'(l_eff);
    if (action_q == ACT_WRITE) begin
      entry.op = cell_ok ? OP_WRITE : OP_DROP;
      entry.x  = XW'(cell_x_q);
      entry.z  = XW'(cell_z_q);
    end else begin
      entry.op = (x_in && z_in) ? OP_QUERY : OP_MISS;
      entry.x  = XW'(ix);
      entry.z  = XW'(iz);
    end
  end

  assign entry_o = entry;

endmodule

>>> rtl/core/thi_queue.sv
module thi_queue import thi_pkg::*; #(
  parameter int W = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [W-1:0]  data_i,
  input  logic          pop_i,
  output logic [W-1:0]  head_o,
  output queue_status_t status_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]    slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign head_o         = slot_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(QUEUE_DEPTH));

endmodule

>>> rtl/core/thi_back.sv
module thi_back import thi_pkg::*; #(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [entry_width($clog2(MAX_SIDE), FRAC_BITS)-1:0] head_i,
  input  queue_status_t                             q_status_i,
  output logic                                      pop_o,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic [OUT_W-1:0]                          height_q8_o,
  output logic                                      out_of_range_o
);

  localparam int F         = FRAC_BITS;
  localparam int XW        = $clog2(MAX_SIDE);
  localparam int HB        = (XW > 1) ? XW - 1 : 1;
  localparam int BankDepth = 1 << (2 * HB);
  localparam int CV        = HEIGHT_W + 2;
  localparam int TW        = CV + F + 2;
  localparam int HW        = TW + F + 2;
  localparam int Sh        = 2 * F - OUT_FRAC_W;
  localparam logic [F:0]    S         = (F + 1)'(1) << F;
  localparam logic [HW-2:0] RoundHalf = ((HW - 1)'(1) << Sh) >> 1;

  typedef struct packed {
    op_e                 op;
    logic [XW-1:0]       x;
    logic [XW-1:0]       z;
    logic                xinc;
    logic                zinc;
    logic [F-1:0]        fx;
    logic [F-1:0]        fz;
    logic                rev;
    logic [HEIGHT_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic         oor;
    logic         x0;
    logic         z0;
    logic         xinc;
    logic         zinc;
    logic [F-1:0] fx;
    logic [F-1:0] fz;
    logic         rev;
  } meta_t;

  entry_t               head;
  logic                 adv;
  logic [XW-1:0]        x_nx;
  logic [XW-1:0]        z_nx;
  logic [2*HB-1:0]      raddr [4];
  logic [HEIGHT_W-1:0]  rd_data [4];

  logic                 b1_valid_q;
  meta_t                b1_q;

  logic signed [CV-1:0] bl;
  logic signed [CV-1:0] br;
  logic signed [CV-1:0] tl;
  logic signed [CV-1:0] tr;
  logic signed [CV-1:0] bl0;
  logic signed [CV-1:0] br0;
  logic signed [CV-1:0] tl0;
  logic signed [CV-1:0] tr0;
  logic [F:0]           sum_f;
  logic [F:0]           sfx;
  logic signed [TW-1:0] top_d;
  logic signed [TW-1:0] bot_d;

  logic                 b2_valid_q;
  logic                 b2_oor_q;
  logic signed [TW-1:0] top_q;
  logic signed [TW-1:0] bot_q;
  logic [F-1:0]         fz_q;

  logic [F:0]           sfz;
  logic signed [HW-1:0] h_d;
  logic                 b3_valid_q;
  logic                 b3_oor_q;
  logic signed [HW-1:0] h_q;

  logic [HW-2:0]        h_rnd;
  logic [OUT_W-1:0]     height_d;
  logic                 out_valid_q;
  logic [OUT_W-1:0]     height_q;
  logic                 oor_q;

  assign head  = entry_t'(head_i);
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !q_status_i.empty;

  assign x_nx = head.x + XW'(1);
  assign z_nx = head.z + XW'(1);

  // Four banks by column and row parity: each corner of a cell sits in its own bank.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BankId = 2'(b);

    logic [HEIGHT_W-1:0] mem [BankDepth];
    logic [HEIGHT_W-1:0] rd_q;
    logic [XW-1:0]       col;
    logic [XW-1:0]       row;
    logic                wr_en;

    assign col      = (head.x[0] == BankId[0]) ? head.x : x_nx;
    assign row      = (head.z[0] == BankId[1]) ? head.z : z_nx;
    assign raddr[b] = {HB'(row >> 1), HB'(col >> 1)};
    assign wr_en    = pop_o && (head.op == OP_WRITE) && ({head.z[0], head.x[0]} == BankId);

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[raddr[b]] <= head.data;
      end
      if (adv) begin
        rd_q <= mem[raddr[b]];
      end
    end

    assign rd_data[b] = rd_q;
  end

  // Stage 1: memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q  <= !q_status_i.empty && (head.op == OP_QUERY || head.op == OP_MISS);
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= b2_valid_q;
      out_valid_q <= b3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_q.oor  <= (head.op == OP_MISS);
      b1_q.x0   <= head.x[0];
      b1_q.z0   <= head.z[0];
      b1_q.xinc <= head.xinc;
      b1_q.zinc <= head.zinc;
      b1_q.fx   <= head.fx;
      b1_q.fz   <= head.fz;
      b1_q.rev  <= head.rev;
    end
  end

  // Stage 2: pick corners, replace the one off the triangle, blend along x.
  assign bl0 = signed'(CV'(rd_data[{b1_q.z0, b1_q.x0}]));
  assign br0 = signed'(CV'(rd_data[{b1_q.z0, b1_q.x0 ^ b1_q.xinc}]));
  assign tl0 = signed'(CV'(rd_data[{b1_q.z0 ^ b1_q.zinc, b1_q.x0}]));
  assign tr0 = signed'(CV'(rd_data[{b1_q.z0 ^ b1_q.zinc, b1_q.x0 ^ b1_q.xinc}]));

  assign sum_f = (F + 1)'(b1_q.fx) + (F + 1)'(b1_q.fz);
  assign sfx   = S - (F + 1)'(b1_q.fx);

  always_comb begin
    bl = bl0;
    br = br0;
    tl = tl0;
    tr = tr0;
    if (b1_q.rev) begin
      if (b1_q.fz >= b1_q.fx) begin
        br = bl0 + tr0 - tl0;
      end else begin
        tl = tr0 + bl0 - br0;
      end
    end else begin
      if (!sum_f[F]) begin
        tr = tl0 + br0 - bl0;
      end else begin
        bl = tl0 + br0 - tr0;
      end
    end
  end

  assign top_d = TW'(tl) * TW'(signed'({1'b0, sfx})) + TW'(tr) * TW'(signed'({2'b0, b1_q.fx}));
  assign bot_d = TW'(bl) * TW'(signed'({1'b0, sfx})) + TW'(br) * TW'(signed'({2'b0, b1_q.fx}));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b2_oor_q <= b1_q.oor;
      top_q    <= top_d;
      bot_q    <= bot_d;
      fz_q     <= b1_q.fz;
    end
  end

  // Stage 3: blend along z.
  assign sfz = S - (F + 1)'(fz_q);
  assign h_d = HW'(bot_q) * HW'(signed'({1'b0, sfz})) + HW'(top_q) * HW'(signed'({2'b0, fz_q}));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b3_oor_q <= b2_oor_q;
      h_q      <= h_d;
    end
  end

  // Stage 4: round half up to Q8.8 and clamp.
  assign h_rnd = (h_q[HW-2:0] + RoundHalf) >> Sh;

  always_comb begin
    if (b3_oor_q || h_q[HW-1]) begin
      height_d = '0;
    end else if (h_rnd > (HW - 1)'(HEIGHT_Q8_MAX)) begin
      height_d = OUT_W'(HEIGHT_Q8_MAX);
    end else begin
      height_d = h_rnd[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      height_q <= height_d;
      oor_q    <= b3_oor_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign height_q8_o    = height_q;
  assign out_of_range_o = oor_q;

endmodule

>>> dv/terrain_height_interpolator_test.sv
`timescale 1ns / 100ps

// Height map words go in on one channel, interpolated heights come back on the other.
// A local model of the store and registers predicts each query result at the moment its
// word is accepted; a separate checker pops the oldest prediction per returned result.
module terrain_height_interpolator_test;
  import thi_pkg::*;

  localparam int     SIDE           = MAX_SIDE_DEF;
  localparam int     FRAC           = FRAC_BITS_DEF;
  localparam longint ONE            = longint'(1) << FRAC;
  localparam int     GRID_SHIFT     = GRID_POINT - FRAC;
  localparam longint POS_MAX        = (longint'(1) << (POS_W - 1)) - 1;
  localparam int     SETTLE_CYCLES  = 16;   // pipeline depth plus queue, with margin
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     HOLD_CYCLES    = 80;

  // One input word as driven on the ports.
  typedef struct {
    logic                    action;
    logic [CELL_W-1:0]       cx;
    logic [CELL_W-1:0]       cz;
    logic [HEIGHT_W-1:0]     hb;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] pz;
    logic                    rev;
  } map_word_t;

  typedef struct {
    logic [OUT_W-1:0] height;
    logic             off_map;
  } height_result_t;

  // Cell picked by a query: corners after clamping and the two fractions.
  typedef struct {
    bit     in_map;
    int     x0;
    int     z0;
    int     x1;
    int     z1;
    longint fx;
    longint fz;
  } quad_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    action_i;
  logic [CELL_W-1:0]       cell_x_i;
  logic [CELL_W-1:0]       cell_z_i;
  logic [HEIGHT_W-1:0]     height_byte_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_z_i;
  logic                    reverse_quad_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [OUT_W-1:0]        height_q8_o;
  logic                    out_of_range_o;

  terrain_height_interpolator dut (.*);

  // Local copy of the store and the registers.
  logic [HEIGHT_W-1:0]  height_map [SIDE*SIDE];
  bit                   height_known [SIDE*SIDE];
  logic [CFG_DIM_W-1:0] map_cols;
  logic [CFG_DIM_W-1:0] map_rows;
  logic [INV_W-1:0]     inv_x;
  logic [INV_W-1:0]     inv_z;

  // Heights predicted for queries accepted but not yet returned, oldest first.
  height_result_t pending_heights [$];

  int errors        = 0;
  int n_writes      = 0;
  int n_queries     = 0;
  int n_off_map     = 0;
  int n_settings    = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 66;
  int hold_request  = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------
  // Model of the block
  // ---------------------------------------------------------------------------------------

  function automatic int spot(input int x, input int z);
    return z * SIDE + x;
  endfunction

  function automatic longint stored(input int x, input int z);
    return longint'(height_map[spot(x, z)]);
  endfunction

  // Register values above the store size act as the store size.
  function automatic int cols_in_use();
    return (map_cols > SIDE) ? SIDE : int'(map_cols);
  endfunction

  function automatic int rows_in_use();
    return (map_rows > SIDE) ? SIDE : int'(map_rows);
  endfunction

  // Scale a world position to grid units and find its cell; a negative product or a cell
  // past the used area puts the query off the map.
  function automatic quad_t locate(input logic signed [POS_W-1:0] px,
                                   input logic signed [POS_W-1:0] pz);
    quad_t  q;
    longint gx;
    longint gz;
    int     w;
    int     l;
    w = cols_in_use();
    l = rows_in_use();
    gx = longint'(px) * longint'(inv_x);
    gz = longint'(pz) * longint'(inv_z);
    q.in_map = (gx >= 0) && (gz >= 0);
    gx = gx >>> GRID_SHIFT;
    gz = gz >>> GRID_SHIFT;
    q.in_map = q.in_map && ((gx >>> FRAC) < w) && ((gz >>> FRAC) < l);
    q.x0 = int'(gx >>> FRAC);
    q.z0 = int'(gz >>> FRAC);
    q.fx = gx & (ONE - 1);
    q.fz = gz & (ONE - 1);
    // Clamp the far corners at the last column and row.
    q.x1 = (q.x0 + 1 < w) ? q.x0 + 1 : w - 1;
    q.z1 = (q.z0 + 1 < l) ? q.z0 + 1 : l - 1;
    return q;
  endfunction

  function automatic height_result_t predict_height(input logic signed [POS_W-1:0] px,
                                                    input logic signed [POS_W-1:0] pz,
                                                    input logic rev);
    quad_t          q;
    height_result_t r;
    longint         bl, br, tl, tr, top, bot, h;
    q = locate(px, pz);
    r.height  = '0;
    r.off_map = !q.in_map;
    if (q.in_map) begin
      bl = stored(q.x0, q.z0);
      br = stored(q.x1, q.z0);
      tl = stored(q.x0, q.z1);
      tr = stored(q.x1, q.z1);
      // Replace the corner off the chosen triangle with its in-plane estimate.
      if (rev) begin
        if (q.fz >= q.fx) br = bl + (tr - tl);
        else tl = tr + (bl - br);
      end else begin
        if (q.fx + q.fz < ONE) tr = tl + (br - bl);
        else bl = tl + (br - tr);
      end
      top = tl * (ONE - q.fx) + tr * q.fx;
      bot = bl * (ONE - q.fx) + br * q.fx;
      h = bot * (ONE - q.fz) + top * q.fz;
      if (h < 0) h = 0;
      // Round half up from 2*FRAC fraction bits down to Q8.8, then saturate.
      h = (h + (longint'(1) <<< (2 * FRAC - OUT_FRAC_W - 1))) >>> (2 * FRAC - OUT_FRAC_W);
      if (h > HEIGHT_Q8_MAX) h = HEIGHT_Q8_MAX;
      r.height = OUT_W'(h);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then fold it into the model. Valid is left
  // high so a back-to-back word needs no second assignment in the same step.
  task automatic send_word(input map_word_t w);
    if ($urandom_range(1, 100) <= send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(1, 100) <= send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    action_i       <= w.action;
    cell_x_i       <= w.cx;
    cell_z_i       <= w.cz;
    height_byte_i  <= w.hb;
    pos_x_i        <= w.px;
    pos_z_i        <= w.pz;
    reverse_quad_i <= w.rev;
    do @(posedge clk_i); while (in_stall_o);
    if (w.action == ACT_WRITE) begin
      height_map[spot(w.cx, w.cz)]   = w.hb;
      height_known[spot(w.cx, w.cz)] = 1'b1;
      n_writes++;
    end else begin
      pending_heights.push_back(predict_height(w.px, w.pz, w.rev));
      n_queries++;
    end
  endtask

  // Fields a word does not use carry random values, so every port bit toggles.
  task automatic send_height(input int x, input int z, input int h);
    map_word_t w;
    w.action = ACT_WRITE;
    w.cx     = CELL_W'(x);
    w.cz     = CELL_W'(z);
    w.hb     = HEIGHT_W'(h);
    w.px     = POS_W'($urandom);
    w.pz     = POS_W'($urandom);
    w.rev    = 1'($urandom);
    send_word(w);
  endtask

  // Write any corner the query would read that has no height yet, then send the query.
  task automatic query_at(input logic signed [POS_W-1:0] px,
                          input logic signed [POS_W-1:0] pz, input logic rev);
    quad_t     q;
    int        xs [2];
    int        zs [2];
    map_word_t w;
    q = locate(px, pz);
    if (q.in_map) begin
      xs = '{q.x0, q.x1};
      zs = '{q.z0, q.z1};
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          if (!height_known[spot(xs[i], zs[j])])
            send_height(xs[i], zs[j], $urandom_range(0, 255));
        end
      end
    end
    w.action = ACT_QUERY;
    w.cx     = CELL_W'($urandom);
    w.cz     = CELL_W'($urandom);
    w.hb     = HEIGHT_W'($urandom);
    w.px     = px;
    w.pz     = pz;
    w.rev    = rev;
    send_word(w);
  endtask

  // World position that lands near grid coordinate g (Q.8) at reciprocal scale inv.
  function automatic logic signed [POS_W-1:0] pos_for_grid(input longint g,
                                                           input logic [INV_W-1:0] inv);
    longint p;
    if (inv == 0) return POS_W'($urandom);
    p = ((g <<< GRID_SHIFT) + longint'(inv) - 1) / longint'(inv);
    p = p + int'($urandom_range(0, 2)) - 1;
    if (p > POS_MAX) p = POS_MAX;
    return POS_W'(p);
  endfunction

  // Aim at the used area, a little past its far edges so the boundary is hit too.
  task automatic inmap_query();
    longint gx;
    longint gz;
    gx = longint'($urandom_range(0, (cols_in_use() + 1) * int'(ONE) - 1));
    gz = longint'($urandom_range(0, (rows_in_use() + 1) * int'(ONE) - 1));
    query_at(pos_for_grid(gx, inv_x), pos_for_grid(gz, inv_z), 1'($urandom));
  endtask

  // Drop valid, let every result come back and the write words behind them retire.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers while the block is idle.
  task automatic set_map(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] l,
                         input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sz);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  regs [4];
    wait_drained();
    vals = '{w, l, sx, sz};
    regs = '{CFG_MAP_WIDTH, CFG_MAP_LENGTH, CFG_INV_SCALE_X, CFG_INV_SCALE_Z};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (regs[i])
        CFG_MAP_WIDTH: begin
          map_cols = vals[i][CFG_DIM_W-1:0];
        end
        CFG_MAP_LENGTH: begin
          map_rows = vals[i][CFG_DIM_W-1:0];
        end
        CFG_INV_SCALE_X: begin
          inv_x = vals[i][INV_W-1:0];
        end
        default: begin
          inv_z = vals[i][INV_W-1:0];
        end
      endcase
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly small maps; now and then tiny, full size or oversized register values.
  function automatic logic [CFG_DATA_W-1:0] rand_dim();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return CFG_DATA_W'($urandom_range(2, 16));
    if (pick == 7) return CFG_DATA_W'($urandom_range(0, 3));
    if (pick == 8) return CFG_DATA_W'(SIDE);
    return CFG_DATA_W'($urandom_range(SIDE + 1, 1023));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_inv();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: return '0;
      1: return 16'hFFFF;
      2: return CFG_DATA_W'(4096);
      3: return CFG_DATA_W'(2048);
      4: return CFG_DATA_W'(8192);
      default: return CFG_DATA_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset registers: full map at unit spacing, so a position reads directly as grid units.
  task automatic test_directed_corners();
    // Checkerboard cell to tell the two triangles of each diagonal apart.
    send_height(0, 0, 0);
    send_height(1, 0, 255);
    send_height(0, 1, 255);
    send_height(1, 1, 0);
    query_at(0, 0, 1'b0);
    query_at(255, 255, 1'b0);
    query_at(255, 0, 1'b1);
    query_at(0, 255, 1'b1);
    query_at(128, 128, 1'b0);
    query_at(200, 60, 1'b1);
    // Last column and row: far corners clamp back onto the map.
    query_at((511 << 8) + 77, (511 << 8) + 200, 1'b0);
    query_at((510 << 8) + 255, 511 << 8, 1'b1);
    // Flat cell at full height.
    send_height(300, 300, 255);
    send_height(301, 300, 255);
    send_height(300, 301, 255);
    send_height(301, 301, 255);
    query_at((300 << 8) + 128, (300 << 8) + 128, 1'b1);
    // Off the map: past each edge, negative, and the position extremes.
    query_at(512 << 8, 0, 1'b0);
    query_at(0, 512 << 8, 1'b1);
    query_at(-1, 5, 1'b0);
    query_at(5, -8388608, 1'b1);
    query_at(8388607, 8388607, 1'b0);
  endtask

  task automatic test_register_extremes();
    // Smallest regular map.
    set_map(2, 2, 4096, 4096);
    query_at((1 << 8) + 100, (1 << 8) + 30, 1'b0);
    query_at(100, (1 << 8) + 250, 1'b1);
    query_at(2 << 8, 0, 1'b0);
    // One column and row: every corner clamps to the single cell.
    set_map(1, 1, 4096, 4096);
    query_at(77, 190, 1'b1);
    query_at(256, 0, 1'b0);
    // Zero width: every query is off the map.
    set_map(0, 512, 4096, 4096);
    query_at(0, 0, 1'b0);
    // Width keeps its low ten bits; both oversized values act as full size. Maximum scale.
    set_map(16'hFFFF, 600, 16'hFFFF, 16'hFFFF);
    query_at(1, 1, 1'b0);
    query_at(2000, 33, 1'b1);
    query_at(8388607, 0, 1'b0);
    query_at(-1, 0, 1'b1);
    // Zero scale: every position, negative ones too, lands on grid origin.
    set_map(512, 512, 0, 0);
    query_at(-8388608, 8388607, 1'b0);
    query_at(12345, -77, 1'b1);
  endtask

  // Mostly queries aimed at the used area; the rest random writes and random positions.
  task automatic test_random_traffic(input int steps, input int send_pct, input int recv_pct);
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < steps; s++) begin
      if (s % 110 == 0) set_map(rand_dim(), rand_dim(), rand_inv(), rand_inv());
      pick = $urandom_range(0, 99);
      if (pick < 20)
        send_height($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                    $urandom_range(0, 255));
      else if (pick < 30)
        query_at(POS_W'($urandom), POS_W'($urandom), 1'($urandom));
      else
        inmap_query();
    end
  endtask

  // Hold the output for a long stretch while words keep coming, so the queue fills and
  // the input stalls.
  task automatic test_output_hold();
    set_map(8, 8, 4096, 4096);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    repeat (40) inmap_query();
  endtask

  // ---------------------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------------------

  // Receiver stall: a requested hold-off first, else random at the current rate.
  initial begin : out_stall_gen
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(1, 100) <= recv_idle_pct);
      end
    end
  end

  // Compare each returned word with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    height_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: unexpected result, expected none, got height %0d off_map %0b",
                 $time, height_q8_o, out_of_range_o);
        errors++;
      end else begin
        want = pending_heights.pop_front();
        if (want.off_map) n_off_map++;
        if (height_q8_o !== want.height) begin
          $display("%0t: height_q8 mismatch, expected %0d, got %0d",
                   $time, want.height, height_q8_o);
          errors++;
        end
        if (out_of_range_o !== want.off_map) begin
          $display("%0t: out_of_range mismatch, expected %0b, got %0b",
                   $time, want.off_map, out_of_range_o);
          errors++;
        end
      end
    end
  end

  // End the run when no word moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word accepted for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, pending_heights.size());
    $display("[terrain_height_interpolator] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_MAP_WIDTH;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_WRITE;
    cell_x_i       <= '0;
    cell_z_i       <= '0;
    height_byte_i  <= '0;
    pos_x_i        <= '0;
    pos_z_i        <= '0;
    reverse_quad_i <= 1'b0;
    map_cols = MAP_DIM_RESET;
    map_rows = MAP_DIM_RESET;
    inv_x    = INV_SCALE_RESET;
    inv_z    = INV_SCALE_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_register_extremes();
    test_random_traffic(350, 21, 66);
    test_random_traffic(350, 66, 21);
    test_random_traffic(270, 0, 0);
    test_output_hold();
    wait_drained();

    $display("Covered %0d height writes and %0d queries (%0d off the map) in %0d settings,",
             n_writes, n_queries, n_off_map, n_settings);
    $display("with idle and stall on both sides and one long output hold-off.");
    if (errors == 0) begin
      $display("[terrain_height_interpolator] OK");
    end else begin
      $display("[terrain_height_interpolator] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/thi_pkg.sv
rtl/core/thi_front.sv
rtl/core/thi_queue.sv
rtl/core/thi_back.sv
rtl/core/terrain_height_interpolator.sv
dv/terrain_height_interpolator_test.sv
